// File: sv/sorted_priority_queue_top_macros.svh
// assertion macros for the sorted priority queue
// used by sorted_priority_queue_top.sv, no other dependencies
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/spq_pkg.sv
// shared types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_EXTRACT = 2'd1;
    localparam logic [1:0] FUNC_PEEK    = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic signed [31:0] NEG_ONE = -32'sd1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } spq_cmd_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic [4:0]         entry_count;
    } spq_rsp_t;

endpackage

// File: sv/spq_mem.sv
// entry store: one write port, one read port with registered read data
// depends on spq_pkg
module spq_mem #(
    parameter int DEPTH = spq_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [31:0]   wdata,
    input  logic [AW-1:0]        raddr,
    output logic signed [31:0]   rdata
);
    import spq_pkg::*;

    logic signed [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/sorted_priority_queue_top.sv
// sorted max priority queue, circular list in one memory with a head pointer
// depends on spq_pkg, spq_mem and sorted_priority_queue_top_macros.svh
//
// channel   dir  handshake            payload
// cmd       in   start & !busy        spq_cmd_t  (func, value)
// rsp       out  done, one cycle      spq_rsp_t  (result_value, status, entry_count)
//
// strobe in the cycle after the transfer for drops, unused codes and empty inserts
// peek and extract strobe after ST_POP has taken the registered memory read
// insert into a non-empty queue walks the tail down in ST_SHIFT, and ST_PUT0 if it reaches slot 0
// the walk moves one entry per cycle through the single memory read/write port pair
// reset clears count, head and control; entries stay undefined until written
// the receiver cannot stall: a result is offered exactly once
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  spq_pkg::spq_cmd_t cmd,
    output logic              busy,
    output logic              done,
    output spq_pkg::spq_rsp_t rsp
);
    import spq_pkg::*;
    `include "sorted_priority_queue_top_macros.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_PUT0  = 4'b0100,
        ST_POP   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic signed [31:0] val_reg, val_next;
    logic               pop_reg, pop_next;
    logic               done_reg, done_next;
    spq_rsp_t           rsp_reg, rsp_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;
    logic [AW-1:0]      raddr;
    logic signed [31:0] rdata;

    // logical slot to physical address, exact while the slot is at most the depth
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(l);
        if (s >= SW'(CAPACITY))
        begin
            s = s - SW'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [4:0] cnt5(input logic [CW-1:0] c);
        logic [CW+4:0] e;
        e = {5'b0, c};
        return e[4:0];
    endfunction

    spq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        pop_next   = pop_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        we         = 1'b0;
        waddr      = phys(head_reg, idx_reg);
        wdata      = val_reg;
        raddr      = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    val_next = cmd.value;
                    rsp_next.result_value = NEG_ONE;
                    rsp_next.status = STATUS_OK;
                    rsp_next.entry_count = cnt5(count_reg);
                    if (cmd.func == FUNC_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            rsp_next.status = STATUS_FULL;
                            done_next = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            we = 1'b1;
                            waddr = head_reg;
                            wdata = cmd.value;
                            count_next = count_reg + 1'b1;
                            rsp_next.entry_count = cnt5(count_reg + 1'b1);
                            done_next = 1'b1;
                        end
                        else
                        begin
                            idx_next = count_reg;
                            raddr = phys(head_reg, count_reg - 1'b1);
                            state_next = ST_SHIFT;
                        end
                    end
                    else if (cmd.func == FUNC_EXTRACT || cmd.func == FUNC_PEEK)
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.status = STATUS_EMPTY;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            pop_next = (cmd.func == FUNC_EXTRACT);
                            state_next = ST_POP;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_SHIFT:
            begin
                we = 1'b1;
                waddr = phys(head_reg, idx_reg);
                if (rdata >= val_reg)
                begin
                    wdata = val_reg;
                    count_next = count_reg + 1'b1;
                    rsp_next.entry_count = cnt5(count_reg + 1'b1);
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // move entry up one slot, fetch the next lower one
                    wdata = rdata;
                    idx_next = idx_reg - 1'b1;
                    raddr = phys(head_reg, idx_reg - CW'(2));
                    if (idx_reg == CW'(1))
                    begin
                        state_next = ST_PUT0;
                    end
                end
            end
            ST_PUT0:
            begin
                we = 1'b1;
                waddr = head_reg;
                wdata = val_reg;
                count_next = count_reg + 1'b1;
                rsp_next.entry_count = cnt5(count_reg + 1'b1);
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_POP:
            begin
                rsp_next.result_value = rdata;
                if (pop_reg)
                begin
                    head_next = phys(head_reg, CW'(1));
                    count_next = count_reg - 1'b1;
                    rsp_next.entry_count = cnt5(count_reg - 1'b1);
                end
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        pop_reg <= pop_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `SPQ_ASSERT_NOW(a_head_bound, 1'b1, SW'(head_reg) < SW'(CAPACITY), "head out of range")
    `SPQ_ASSERT_NOW(a_done_idle, done_reg, state_reg == ST_IDLE, "result while busy")
    `SPQ_ASSERT_NEXT(a_pop_done, state_reg == ST_POP, done_reg, "peek or extract lost")
    `SPQ_ASSERT_NOW(a_shift_idx, state_reg == ST_SHIFT,
        idx_reg != '0 && idx_reg <= count_reg, "shift slot out of range")

endmodule
